>>> hdl/touch_input_stuck_watchdog_unit_defines.svh
// Assertion macros shared by the touch input stuck watchdog RTL.
`ifndef TOUCH_INPUT_STUCK_WATCHDOG_UNIT_DEFINES_SVH
`define TOUCH_INPUT_STUCK_WATCHDOG_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TISW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tisw same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TISW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tisw next-cycle check failed");

`endif

>>> hdl/tisw_pkg.sv
// Shared types and constants for the touch input stuck watchdog.
package tisw_pkg;

    localparam int SENSOR_COUNT_DEF = 2;
    localparam int MS_W             = 24;
    localparam int ELAPSED_W        = 8;
    localparam int RETRY_W          = 4;
    localparam int COUNT_W          = RETRY_W + 1;
    localparam int CFG_DATA_W       = 32;
    localparam int CFG_ADDR_W       = 4;

    localparam logic [MS_W-1:0]    CHECK_INTERVAL_RST  = MS_W'(1000);
    localparam logic [MS_W-1:0]    STUCK_THRESHOLD_RST = MS_W'(60000);
    localparam logic [RETRY_W-1:0] MAX_RETRIES_RST     = RETRY_W'(3);

    typedef enum logic [1:0] {
        REG_ENABLE_MASK     = 2'd0,
        REG_CHECK_INTERVAL  = 2'd1,
        REG_STUCK_THRESHOLD = 2'd2,
        REG_MAX_RETRIES     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [MS_W-1:0]    check_interval;
        logic [MS_W-1:0]    stuck_threshold;
        logic [RETRY_W-1:0] max_retries;
    } cfg_t;

    typedef struct packed {
        logic en;
        logic check;
        logic advance;
    } lane_ctl_t;

    typedef struct packed {
        logic touched;
        logic changed;
        logic reinit;
        logic stuck;
        logic gave_up;
    } lane_res_t;

endpackage

>>> hdl/tisw_cfg.sv
// Configuration register file with an APB-style slave port.
module tisw_cfg
    import tisw_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_ADDR_W-1:0]   paddr,
    input  logic [CFG_DATA_W-1:0]   pwdata,
    output logic [CFG_DATA_W-1:0]   prdata,
    output logic                    pready,
    output logic [SENSOR_COUNT-1:0] enable_mask,
    output cfg_t                    cfg
);

    logic [SENSOR_COUNT-1:0] enable_mask_reg;
    logic [MS_W-1:0]         check_interval_reg;
    logic [MS_W-1:0]         stuck_threshold_reg;
    logic [RETRY_W-1:0]      max_retries_reg;
    reg_idx_t                reg_idx;
    logic                    wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_mask_reg     <= '1;
            check_interval_reg  <= CHECK_INTERVAL_RST;
            stuck_threshold_reg <= STUCK_THRESHOLD_RST;
            max_retries_reg     <= MAX_RETRIES_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ENABLE_MASK:     enable_mask_reg     <= pwdata[SENSOR_COUNT-1:0];
                REG_CHECK_INTERVAL:  check_interval_reg  <= pwdata[MS_W-1:0];
                REG_STUCK_THRESHOLD: stuck_threshold_reg <= pwdata[MS_W-1:0];
                REG_MAX_RETRIES:     max_retries_reg     <= pwdata[RETRY_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ENABLE_MASK:     prdata = CFG_DATA_W'(enable_mask_reg);
            REG_CHECK_INTERVAL:  prdata = CFG_DATA_W'(check_interval_reg);
            REG_STUCK_THRESHOLD: prdata = CFG_DATA_W'(stuck_threshold_reg);
            REG_MAX_RETRIES:     prdata = CFG_DATA_W'(max_retries_reg);
            default:             prdata = '0;
        endcase
    end

    assign enable_mask         = enable_mask_reg;
    assign cfg.check_interval  = check_interval_reg;
    assign cfg.stuck_threshold = stuck_threshold_reg;
    assign cfg.max_retries     = max_retries_reg;

endmodule

>>> hdl/tisw_lane.sv
// Per-sensor state and decision logic: activity, idle timer, retries, stuck flag.
module tisw_lane
    import tisw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lane_ctl_t            ctl,
    input  logic                 level,
    input  logic [ELAPSED_W-1:0] elapsed,
    input  cfg_t                 cfg,
    output lane_res_t            res
);

    // level_reg is both the previous level and the touched mirror: they only
    // ever change together.
    logic               level_reg;
    logic [MS_W-1:0]    idle_reg;
    logic [COUNT_W-1:0] retry_reg;
    logic               stuck_reg;

    logic               level_next;
    logic [MS_W-1:0]    idle_next;
    logic [COUNT_W-1:0] retry_next;
    logic               stuck_next;
    logic [MS_W:0]      idle_sum;
    logic               act;
    logic               reinit;
    logic               gave_up;

    always_comb
    begin
        idle_sum   = {1'b0, idle_reg} + (MS_W+1)'(elapsed);
        act        = ctl.en && (level != level_reg);
        level_next = ctl.en ? level : level_reg;
        idle_next  = act ? '0 : (idle_sum[MS_W] ? '1 : idle_sum[MS_W-1:0]);
        retry_next = act ? '0 : retry_reg;
        stuck_next = act ? 1'b0 : stuck_reg;
        reinit     = 1'b0;
        gave_up    = 1'b0;
        if (ctl.check && ctl.en && (idle_next > cfg.stuck_threshold))
        begin
            if (retry_next < COUNT_W'(cfg.max_retries))
            begin
                stuck_next = 1'b1;
                reinit     = 1'b1;
                idle_next  = '0;
                retry_next = retry_next + COUNT_W'(1);
            end
            else if (retry_next == COUNT_W'(cfg.max_retries))
            begin
                // one step past the limit, so the give-up pulse does not repeat until activity
                gave_up    = 1'b1;
                retry_next = retry_next + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b0;
            idle_reg  <= '0;
            retry_reg <= '0;
            stuck_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            level_reg <= level_next;
            idle_reg  <= idle_next;
            retry_reg <= retry_next;
            stuck_reg <= stuck_next;
        end
    end

    assign res.touched = level_next;
    assign res.changed = act;
    assign res.reinit  = reinit;
    assign res.stuck   = stuck_next;
    assign res.gave_up = gave_up;

endmodule

>>> hdl/touch_input_stuck_watchdog_unit.sv
// Top level of the touch input stuck watchdog: input beat register, check timer, lanes, result.
// An accepted poll beat passes through the input beat register, then the result register, to the master side.
// Throughput: one poll beat per cycle; the input register and the result register
// both advance together whenever the result register is empty or being drained.
// Reset (rst_n, async, active low): timers, retries, flags and mirrors clear;
// registers return to enable all, interval 1000, threshold 60000, retries 3.
`include "touch_input_stuck_watchdog_unit_defines.svh"

module touch_input_stuck_watchdog_unit
    import tisw_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
    localparam int IN_TDATA_W  = ((SENSOR_COUNT + ELAPSED_W + 7) / 8) * 8,
    localparam int RES_W       = 5 * SENSOR_COUNT,
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // APB-style configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready,
    // poll beats in
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // levels, elapsed_ms, zero pad
    // result beats out
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata   // touched, changed, reinit_request,
                                             // stuck, gave_up, zero pad
);

    logic [SENSOR_COUNT-1:0] enable_mask;
    cfg_t                    cfg;

    // input beat register
    logic                    in_valid_reg;
    logic [SENSOR_COUNT-1:0] levels_reg;
    logic [ELAPSED_W-1:0]    elapsed_reg;

    // health check timer
    logic [MS_W-1:0]         check_reg;
    logic [MS_W-1:0]         check_next;
    logic [MS_W:0]           check_sum;
    logic [MS_W-1:0]         check_sat;
    logic                    check_now;

    // result register
    logic                    out_valid_reg;
    logic [RES_W-1:0]        result_reg;
    logic [RES_W-1:0]        result_next;

    logic                    advance;
    logic [SENSOR_COUNT-1:0] touched_v;
    logic [SENSOR_COUNT-1:0] changed_v;
    logic [SENSOR_COUNT-1:0] reinit_v;
    logic [SENSOR_COUNT-1:0] stuck_v;
    logic [SENSOR_COUNT-1:0] gave_up_v;

    tisw_cfg #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .enable_mask (enable_mask),
        .cfg         (cfg)
    );

    // A held beat is processed when the result register is free or drains this
    // cycle; the input register refills in the same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            levels_reg  <= s_tdata[SENSOR_COUNT-1:0];
            elapsed_reg <= s_tdata[SENSOR_COUNT +: ELAPSED_W];
        end
    end

    // Check timer saturates, then clears once it reaches the interval
    // (a zero interval therefore checks on every poll).
    always_comb
    begin
        check_sum  = {1'b0, check_reg} + (MS_W+1)'(elapsed_reg);
        check_sat  = check_sum[MS_W] ? '1 : check_sum[MS_W-1:0];
        check_now  = (check_sat >= cfg.check_interval);
        check_next = check_now ? '0 : check_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_reg <= '0;
        end
        else if (advance)
        begin
            check_reg <= check_next;
        end
    end

    for (genvar i = 0; i < SENSOR_COUNT; i++)
    begin : g_lane
        lane_ctl_t ctl;
        lane_res_t res;

        assign ctl.en      = enable_mask[i];
        assign ctl.check   = check_now;
        assign ctl.advance = advance;

        tisw_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .level   (levels_reg[i]),
            .elapsed (elapsed_reg),
            .cfg     (cfg),
            .res     (res)
        );

        assign touched_v[i] = res.touched;
        assign changed_v[i] = res.changed;
        assign reinit_v[i]  = res.reinit;
        assign stuck_v[i]   = res.stuck;
        assign gave_up_v[i] = res.gave_up;
    end

    assign result_next = {gave_up_v, stuck_v, reinit_v, changed_v, touched_v};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(result_reg);

    // A processed beat always lands in the result register.
    `TISW_ASSERT_NEXT(a_advance_fills_out, clk, rst_n, advance, out_valid_reg)
    // A held beat that cannot move stays held.
    `TISW_ASSERT_NEXT(a_in_held, clk, rst_n, in_valid_reg && !advance, in_valid_reg)
    // A reinit pulse always comes with the stuck flag set.
    `TISW_ASSERT_NOW(a_reinit_sets_stuck, clk, rst_n, out_valid_reg,
        (result_reg[2*SENSOR_COUNT +: SENSOR_COUNT] &
         ~result_reg[3*SENSOR_COUNT +: SENSOR_COUNT]) == '0)
    // Reinit and give-up never fire for the same sensor in one poll.
    `TISW_ASSERT_NOW(a_reinit_xor_gave_up, clk, rst_n, out_valid_reg,
        (result_reg[2*SENSOR_COUNT +: SENSOR_COUNT] &
         result_reg[4*SENSOR_COUNT +: SENSOR_COUNT]) == '0)

endmodule

>>> sim/touch_input_stuck_watchdog_unit_tb.sv
// Self-checking testbench for touch_input_stuck_watchdog_unit: stream polls in, compare results.
module touch_input_stuck_watchdog_unit_tb;
    import tisw_pkg::*;

    localparam int NS          = SENSOR_COUNT_DEF;
    localparam int IN_TDATA_W  = ((NS + ELAPSED_W + 7) / 8) * 8;
    localparam int RES_W       = 5 * NS;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam int PIPE_DEPTH  = 2;     // poll beat to result beat: input beat register, then result register
    localparam int QUIET_LIMIT = 5000;  // longest correct gap is the receiver hold-off
    localparam int HOLD_OFF    = 300;

    // One poll beat; packed so that levels land in the low bits of tdata.
    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed;
        logic [NS-1:0]        levels;
    } poll_t;

    // One result beat; touched sits lowest, gave_up highest.
    typedef struct packed {
        logic [NS-1:0] gave_up;
        logic [NS-1:0] stuck;
        logic [NS-1:0] reinit;
        logic [NS-1:0] changed;
        logic [NS-1:0] touched;
    } poll_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr = '0;
    logic [CFG_DATA_W-1:0]  pwdata = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // levels, elapsed_ms, zero pad
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // touched, changed, reinit_request,
                                            // stuck, gave_up, zero pad

    touch_input_stuck_watchdog_unit #(.SENSOR_COUNT(NS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Watchdog model: register shadow plus per-sensor state
    // ------------------------------------------------------------------
    logic [NS-1:0]        cfg_enable    = '1;
    logic [MS_W-1:0]      cfg_interval  = CHECK_INTERVAL_RST;
    logic [MS_W-1:0]      cfg_threshold = STUCK_THRESHOLD_RST;
    logic [RETRY_W-1:0]   cfg_retries   = MAX_RETRIES_RST;

    logic [NS-1:0]        last_level = '0;
    logic [NS-1:0]        mirror     = '0;
    logic [NS-1:0]        stuck_flag = '0;
    logic [MS_W-1:0]      idle_ms [NS] = '{default: '0};
    logic [COUNT_W-1:0]   retries [NS] = '{default: '0};
    logic [MS_W-1:0]      check_ms   = '0;

    poll_t        pending_polls[$];
    poll_result_t expected_results[$];
    poll_t        poll_on_bus;

    int idle_pct      = 36;   // sender gap odds, percent
    int stall_pct     = 36;   // receiver stall odds, percent
    int hold_off_left = 0;    // receiver hold-off, counted down by the result monitor
    int mismatches    = 0;
    int polls_sent    = 0;
    int results_seen  = 0;
    int reinit_pulses = 0;
    int giveup_pulses = 0;
    int reg_writes    = 0;
    int quiet_cycles  = 0;

    function automatic logic [MS_W-1:0] sat_ms(logic [MS_W-1:0] a, logic [ELAPSED_W-1:0] b);
        logic [MS_W:0] sum;
        sum = a + b;
        return sum[MS_W] ? {MS_W{1'b1}} : sum[MS_W-1:0];
    endfunction

    // Advance the model by one poll and return the result beat it should produce.
    function automatic poll_result_t step_watchdog(poll_t p);
        poll_result_t r;
        r = '0;
        // Activity pass: idle time always advances, a level change on an
        // enabled sensor wipes the idle time, retries and stuck flag.
        for (int i = 0; i < NS; i++)
        begin
            idle_ms[i] = sat_ms(idle_ms[i], p.elapsed);
            if (cfg_enable[i])
            begin
                if (p.levels[i] != last_level[i])
                begin
                    r.changed[i]  = 1'b1;
                    last_level[i] = p.levels[i];
                    idle_ms[i]    = '0;
                    retries[i]    = '0;
                    stuck_flag[i] = 1'b0;
                end
                mirror[i] = p.levels[i];
            end
        end
        // Health check once the interval has run out (every poll for zero).
        check_ms = sat_ms(check_ms, p.elapsed);
        if (check_ms >= cfg_interval)
        begin
            check_ms = '0;
            for (int i = 0; i < NS; i++)
            begin
                if (cfg_enable[i] && idle_ms[i] > cfg_threshold)
                begin
                    if (retries[i] < cfg_retries)
                    begin
                        stuck_flag[i] = 1'b1;
                        r.reinit[i]   = 1'b1;
                        idle_ms[i]    = '0;
                        retries[i]    = retries[i] + 1'b1;
                    end
                    else if (retries[i] == cfg_retries)
                    begin
                        // one give-up pulse, then silent until activity
                        r.gave_up[i] = 1'b1;
                        retries[i]   = retries[i] + 1'b1;
                    end
                end
            end
        end
        r.touched = mirror;
        r.stuck   = stuck_flag;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Poll driver: accepted beats feed the model, then the next beat goes up
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_polls
        logic offer;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                poll_result_t r;
                r = step_watchdog(poll_on_bus);
                expected_results.push_back(r);
                reinit_pulses += $countones(r.reinit);
                giveup_pulses += $countones(r.gave_up);
                polls_sent++;
            end
            // beat is free to change only when nothing is pending on the bus
            if (!s_tvalid || s_tready)
            begin
                offer = (pending_polls.size() != 0) && ($urandom_range(99) >= idle_pct);
                if (offer)
                begin
                    poll_on_bus = pending_polls.pop_front();
                    s_tdata  <= IN_TDATA_W'(poll_on_bus);
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [NS-1:0] want, logic [NS-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result monitor: compare each beat against the oldest prediction,
    // then choose the next ready (random stalls or a counted hold-off)
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_results
        poll_result_t want;
        poll_result_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got = poll_result_t'(m_tdata[RES_W-1:0]);
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, expected none actual %0h",
                             $time, got);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("touched", want.touched, got.touched);
                    check_field("changed", want.changed, got.changed);
                    check_field("reinit_request", want.reinit, got.reinit);
                    check_field("stuck", want.stuck, got.stuck);
                    check_field("gave_up", want.gave_up, got.gave_up);
                end
            end
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Stall watchdog: any accepted beat on either side restarts the count.
    always @(posedge clk)
    begin : stall_watch
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
                $display("touch_input_stuck_watchdog_unit regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // APB write: setup then access; the DUT latches at the access edge.
    // Junk goes into the bits above each register's width, which must be dropped.
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        logic [31:0] word;
        word = $urandom();
        case (idx)
            REG_ENABLE_MASK:     word[NS-1:0]      = value[NS-1:0];
            REG_CHECK_INTERVAL:  word[MS_W-1:0]    = value[MS_W-1:0];
            REG_STUCK_THRESHOLD: word[MS_W-1:0]    = value[MS_W-1:0];
            default:             word[RETRY_W-1:0] = value[RETRY_W-1:0];
        endcase
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENABLE_MASK:     cfg_enable    = word[NS-1:0];
            REG_CHECK_INTERVAL:  cfg_interval  = word[MS_W-1:0];
            REG_STUCK_THRESHOLD: cfg_threshold = word[MS_W-1:0];
            default:             cfg_retries   = word[RETRY_W-1:0];
        endcase
        reg_writes++;
    endtask

    task automatic set_config(logic [NS-1:0] en, logic [MS_W-1:0] interval,
                              logic [MS_W-1:0] threshold, logic [RETRY_W-1:0] max_retry);
        write_reg(REG_ENABLE_MASK, 32'(en));
        write_reg(REG_CHECK_INTERVAL, 32'(interval));
        write_reg(REG_STUCK_THRESHOLD, 32'(threshold));
        write_reg(REG_MAX_RETRIES, 32'(max_retry));
    endtask

    task automatic push_poll(logic [NS-1:0] levels, logic [ELAPSED_W-1:0] elapsed);
        poll_t p;
        p.levels  = levels;
        p.elapsed = elapsed;
        pending_polls.push_back(p);
    endtask

    // Wait until every poll is accepted and answered, then let the pipe settle.
    task automatic wait_drained();
        while (pending_polls.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // Mostly held levels so idle time builds up toward the threshold;
    // occasional single-bit flips, some fully random noise, biased elapsed.
    task automatic queue_random_polls(int count);
        logic [NS-1:0] held;
        poll_t         p;
        int            pick;
        held = NS'($urandom());
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                held[$urandom_range(NS-1)] ^= 1'b1;
            p.levels = (pick >= 88) ? NS'($urandom()) : held;
            pick = $urandom_range(9);
            if (pick == 0)
                p.elapsed = '0;
            else if (pick == 1)
                p.elapsed = '1;
            else
                p.elapsed = ELAPSED_W'($urandom());
            pending_polls.push_back(p);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset config: touch edges, elapsed extremes, routine checks.
        push_poll(2'b00, 8'd0);
        push_poll(2'b11, 8'd255);
        push_poll(2'b11, 8'd255);
        push_poll(2'b01, 8'd0);
        push_poll(2'b10, 8'd200);
        push_poll(2'b00, 8'd255);
        push_poll(2'b11, 8'd128);
        push_poll(2'b11, 8'd255);
        wait_drained();

        // Zero interval and zero retries: first stuck verdict is a bare give-up,
        // then silence until the sensor moves again.
        set_config(2'b11, '0, '0, '0);
        push_poll(2'b11, 8'd1);
        push_poll(2'b11, 8'd5);
        push_poll(2'b10, 8'd0);
        push_poll(2'b10, 8'd3);
        push_poll(2'b10, 8'd3);
        wait_drained();

        // Sensor 1 disabled: its level is ignored and its mirror, retries and stuck flag held.
        // Walk sensor 0 through reinit, reinit, give-up, then a change landing
        // in the same poll as a big elapsed step.
        set_config(2'b01, '0, 24'd10, 4'd2);
        push_poll(2'b11, 8'd20);
        push_poll(2'b01, 8'd20);
        push_poll(2'b01, 8'd11);
        push_poll(2'b01, 8'd11);
        push_poll(2'b01, 8'd11);
        push_poll(2'b00, 8'd255);
        push_poll(2'b10, 8'd255);
        push_poll(2'b10, 8'd255);
        wait_drained();

        // Random phases. The first one opens with a long receiver hold-off
        // while the sender keeps offering, so the pipe backs up to the input.
        set_config(2'b11, MS_W'($urandom_range(600)), MS_W'($urandom_range(1500)),
                   RETRY_W'($urandom_range(1, 4)));
        queue_random_polls(270);
        hold_off_left = HOLD_OFF;
        wait_drained();

        set_config(NS'($urandom()), '0, MS_W'($urandom_range(400)), 4'd15);
        queue_random_polls(270);
        wait_drained();

        // everything disabled: mirrors hold while idle time keeps counting
        set_config('0, '0, '0, '0);
        queue_random_polls(100);
        wait_drained();

        set_config(2'b11, {MS_W{1'b1}}, '0, '0);
        queue_random_polls(100);
        wait_drained();

        set_config(2'b11, CHECK_INTERVAL_RST, STUCK_THRESHOLD_RST, MAX_RETRIES_RST);
        queue_random_polls(300);
        wait_drained();

        // Back-to-back stretch: no sender gaps, no receiver stalls.
        idle_pct  = 0;
        stall_pct = 0;
        set_config(NS'($urandom()), MS_W'($urandom_range(800)), MS_W'($urandom_range(2000)),
                   RETRY_W'($urandom()));
        queue_random_polls(300);
        wait_drained();

        repeat (PIPE_DEPTH + 4) @(posedge clk);
        $display("polls %0d, result beats %0d, register writes %0d", polls_sent, results_seen,
                 reg_writes);
        $display("reinit pulses %0d, give-up pulses %0d, mismatches %0d", reinit_pulses,
                 giveup_pulses, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("touch_input_stuck_watchdog_unit regression: pass");
        else
            $display("touch_input_stuck_watchdog_unit regression: fail");
        $finish;
    end

endmodule
